// ===== rtl/vt4_pkg.sv =====
// ----------------------------------------------------------------------------
// vt4_pkg
// Shared widths, register codes and types for the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

    localparam int ROWS            = 4;
    localparam int COEFF_W         = 16;
    localparam int COMP_W          = 32;
    localparam int COEFF_FRAC_BITS = 8;
    localparam int ROW_W           = ROWS * COEFF_W;
    localparam int PROD_W          = COEFF_W + COMP_W;
    localparam int PAIR_W          = PROD_W + 1;
    localparam int SUM_W           = PAIR_W + 1;
    localparam int SHIFT_W         = SUM_W - COEFF_FRAC_BITS;
    localparam int CFG_INDEX_W     = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2,
        REG_ROW3 = 2'd3
    } vt4_reg_idx_t;

    typedef logic [ROWS-1:0][COEFF_W-1:0] vt4_row_t;
    typedef logic [ROWS-1:0][COMP_W-1:0]  vt4_vec_t;

    localparam logic [ROW_W-1:0] ROW_RESET [ROWS] = '{
        64'h0000_0000_0000_0100,
        64'h0000_0000_0100_0000,
        64'h0000_0100_0000_0000,
        64'h0100_0000_0000_0000
    };

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } vt4_adv_t;

endpackage

// ===== rtl/vt4_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vt4_cfg_regs
// Matrix row registers, loaded through the configuration write channel.
// ----------------------------------------------------------------------------
module vt4_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_write,
    input  logic [vt4_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [vt4_pkg::ROW_W-1:0]            cfg_data,
    output vt4_pkg::vt4_row_t                    rows [vt4_pkg::ROWS]
);

    logic [vt4_pkg::ROW_W-1:0] rows_reg  [vt4_pkg::ROWS];
    logic [vt4_pkg::ROW_W-1:0] rows_next [vt4_pkg::ROWS];

    always_comb begin
        for (int i = 0; i < vt4_pkg::ROWS; i++) begin
            rows_next[i] = rows_reg[i];
        end
        if (cfg_write) begin
            unique case (vt4_pkg::vt4_reg_idx_t'(cfg_index))
                vt4_pkg::REG_ROW0: rows_next[0] = cfg_data;
                vt4_pkg::REG_ROW1: rows_next[1] = cfg_data;
                vt4_pkg::REG_ROW2: rows_next[2] = cfg_data;
                vt4_pkg::REG_ROW3: rows_next[3] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < vt4_pkg::ROWS; i++) begin
            if (!aresetn) begin
                rows_reg[i] <= vt4_pkg::ROW_RESET[i];
            end else begin
                rows_reg[i] <= rows_next[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < vt4_pkg::ROWS; i++) begin
            rows[i] = rows_reg[i];
        end
    end

endmodule

// ===== rtl/vt4_dot_row.sv =====
// ----------------------------------------------------------------------------
// vt4_dot_row
// One output row: multiply, pair add, final add and shift, saturate.
// ----------------------------------------------------------------------------
module vt4_dot_row (
    input  logic                              aclk,
    input  vt4_pkg::vt4_adv_t                 adv,
    input  vt4_pkg::vt4_row_t                 row_coeffs,
    input  vt4_pkg::vt4_vec_t                 vertex,
    output logic [vt4_pkg::COMP_W-1:0]        result,
    output logic                              clip
);

    logic signed [vt4_pkg::PROD_W-1:0]  prod_reg  [vt4_pkg::ROWS];
    logic signed [vt4_pkg::PROD_W-1:0]  prod_next [vt4_pkg::ROWS];
    logic signed [vt4_pkg::PAIR_W-1:0]  pair_reg  [2];
    logic signed [vt4_pkg::PAIR_W-1:0]  pair_next [2];
    logic signed [vt4_pkg::SUM_W-1:0]   sum_next;
    logic [vt4_pkg::SHIFT_W-1:0]        shifted_reg;
    logic [vt4_pkg::SHIFT_W-1:0]        shifted_next;
    logic [vt4_pkg::SHIFT_W-vt4_pkg::COMP_W:0] high_bits;
    logic                               overflow;
    logic [vt4_pkg::COMP_W-1:0]         result_reg;
    logic [vt4_pkg::COMP_W-1:0]         result_next;
    logic                               clip_reg;

    always_comb begin
        for (int j = 0; j < vt4_pkg::ROWS; j++) begin
            prod_next[j] = $signed(row_coeffs[j]) * $signed(vertex[j]);
        end
    end

    always_comb begin
        pair_next[0] = vt4_pkg::PAIR_W'(prod_reg[0]) + vt4_pkg::PAIR_W'(prod_reg[1]);
        pair_next[1] = vt4_pkg::PAIR_W'(prod_reg[2]) + vt4_pkg::PAIR_W'(prod_reg[3]);
    end

    always_comb begin
        sum_next     = vt4_pkg::SUM_W'(pair_reg[0]) + vt4_pkg::SUM_W'(pair_reg[1]);
        shifted_next = sum_next[vt4_pkg::SUM_W-1:vt4_pkg::COEFF_FRAC_BITS];
    end

    always_comb begin
        high_bits = shifted_reg[vt4_pkg::SHIFT_W-1:vt4_pkg::COMP_W-1];
        overflow  = !((&high_bits) || !(|high_bits));
        if (overflow) begin
            result_next = shifted_reg[vt4_pkg::SHIFT_W-1]
                        ? {1'b1, {(vt4_pkg::COMP_W-1){1'b0}}}
                        : {1'b0, {(vt4_pkg::COMP_W-1){1'b1}}};
        end else begin
            result_next = shifted_reg[vt4_pkg::COMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.en1) begin
            for (int j = 0; j < vt4_pkg::ROWS; j++) begin
                prod_reg[j] <= prod_next[j];
            end
        end
        if (adv.en2) begin
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
        end
        if (adv.en3) begin
            shifted_reg <= shifted_next;
        end
        if (adv.en4) begin
            result_reg <= result_next;
            clip_reg   <= overflow;
        end
    end

    assign result = result_reg;
    assign clip   = clip_reg;

endmodule

// ===== rtl/vertex_transform_4x4_unit.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_4x4_unit
// Fixed-point 4x4 matrix times homogeneous vertex, four-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | direction | ports                        | transaction
//  ---------+-----------+------------------------------+---------------------
//  s_       | in        | s_tvalid s_tready s_tdata    | one vertex x,y,z,w
//  m_       | out       | m_tvalid m_tready m_tdata/u  | transformed vertex
//  cfg_     | in        | cfg_valid cfg_ready idx data | one matrix row write
//
//  One vertex per cycle while m_tready holds high; an accepted vertex passes through
//  multiply, pair add, final add with shift, and saturate into output register, then m_tvalid.
//  Each stage holds its own valid bit and advances when empty or drained, so
//  bubbles close up during a stall and nothing is lost or repeated.
//  Reset clears all valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [4*vt4_pkg::COMP_W-1:0]      s_tdata,   // in_x, in_y, in_z, in_w
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [4*vt4_pkg::COMP_W-1:0]      m_tdata,   // out_x, out_y, out_z, out_w
    output logic                              m_tuser,   // clipped
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vt4_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [vt4_pkg::ROW_W-1:0]         cfg_data
);

    vt4_pkg::vt4_adv_t  adv;
    vt4_pkg::vt4_row_t  rows [vt4_pkg::ROWS];
    vt4_pkg::vt4_vec_t  vertex;
    vt4_pkg::vt4_vec_t  results;
    logic [vt4_pkg::ROWS-1:0] clips;
    logic [3:0] valid_reg;
    logic [3:0] valid_next;

    assign cfg_ready = 1'b1;
    assign vertex    = s_tdata;

    always_comb begin
        adv.en4 = !valid_reg[3] || m_tready;
        adv.en3 = !valid_reg[2] || adv.en4;
        adv.en2 = !valid_reg[1] || adv.en3;
        adv.en1 = !valid_reg[0] || adv.en2;
    end

    always_comb begin
        valid_next[0] = adv.en1 ? s_tvalid     : valid_reg[0];
        valid_next[1] = adv.en2 ? valid_reg[0] : valid_reg[1];
        valid_next[2] = adv.en3 ? valid_reg[1] : valid_reg[2];
        valid_next[3] = adv.en4 ? valid_reg[2] : valid_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    vt4_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rows      (rows)
    );

    for (genvar i = 0; i < vt4_pkg::ROWS; i++) begin : g_row
        vt4_dot_row u_row (
            .aclk       (aclk),
            .adv        (adv),
            .row_coeffs (rows[i]),
            .vertex     (vertex),
            .result     (results[i]),
            .clip       (clips[i])
        );
    end

    assign s_tready = adv.en1;
    assign m_tvalid = valid_reg[3];
    assign m_tdata  = results;
    assign m_tuser  = |clips;

endmodule

// ===== rtl/vt4_checker.sv =====
// ----------------------------------------------------------------------------
// vt4_checker
// Port-level checks for the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
module vt4_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [4*vt4_pkg::COMP_W-1:0]      m_tdata,
    input logic                              m_tuser
);

    localparam logic [vt4_pkg::COMP_W-1:0] SAT_MAX = {1'b0, {(vt4_pkg::COMP_W-1){1'b1}}};
    localparam logic [vt4_pkg::COMP_W-1:0] SAT_MIN = {1'b1, {(vt4_pkg::COMP_W-1){1'b0}}};

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped during stall");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("m_tdata changed during stall");

    a_clip_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[31:0] == SAT_MAX || m_tdata[31:0] == SAT_MIN ||
            m_tdata[63:32] == SAT_MAX || m_tdata[63:32] == SAT_MIN ||
            m_tdata[95:64] == SAT_MAX || m_tdata[95:64] == SAT_MIN ||
            m_tdata[127:96] == SAT_MAX || m_tdata[127:96] == SAT_MIN)
        else $error("clipped set without a saturated component");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> ##4 m_tvalid)
        else $error("accepted vertex did not reach the output in time");

endmodule

bind vertex_transform_4x4_unit vt4_checker u_vt4_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
